// ===== hdl/ufbs_pkg.sv =====
// ----------------------------------------------------------------------------
// ufbs_pkg
// Shared widths, constants and types of the fractional baud divider search.
// ----------------------------------------------------------------------------
package ufbs_pkg;

   localparam int BAUD_W     = 23;
   localparam int PCLK_W     = 27;
   localparam int DIVISOR_W  = 16;
   localparam int FRAC_W     = 4;
   localparam int DIVIDEND_W = PCLK_W;
   localparam int DSR_W      = BAUD_W;
   localparam int CNT_W      = $clog2(DIVIDEND_W);

   localparam logic [PCLK_W-1:0] PCLK_RESET = PCLK_W'(25000000);
   localparam logic [FRAC_W-1:0] ADD_FIRST  = FRAC_W'(1);
   localparam logic [FRAC_W-1:0] ADD_LAST   = FRAC_W'(14);
   localparam logic [FRAC_W-1:0] MUL_LAST   = FRAC_W'(15);

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [7:0] {
      ST_IDLE       = 8'b0000_0001,
      ST_PLAIN_GO   = 8'b0000_0010,
      ST_PLAIN_WAIT = 8'b0000_0100,
      ST_SCALE_GO   = 8'b0000_1000,
      ST_SCALE_WAIT = 8'b0001_0000,
      ST_MOD_GO     = 8'b0010_0000,
      ST_MOD_WAIT   = 8'b0100_0000,
      ST_FINISH     = 8'b1000_0000
   } state_type;

endpackage

// ===== hdl/ufbs_div.sv =====
// ----------------------------------------------------------------------------
// ufbs_div
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module ufbs_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ufbs_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [ufbs_pkg::DSR_W-1:0]      divisor,
   output logic [ufbs_pkg::DIVIDEND_W-1:0] quotient,
   output logic [ufbs_pkg::DSR_W-1:0]      remainder,
   output ufbs_pkg::div_status_type        status
);

   localparam int DW = ufbs_pkg::DIVIDEND_W;
   localparam int SW = ufbs_pkg::DSR_W;
   localparam int CW = ufbs_pkg::CNT_W;
   localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [SW-1:0] dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [SW:0]   trial;
   logic [SW:0]   diff;
   logic          fits;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DW-2:0], fits};
         rem_in = fits ? diff[SW-1:0] : trial[SW-1:0];
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== hdl/uart_fractional_baud_search.sv =====
// ----------------------------------------------------------------------------
// uart_fractional_baud_search
// Finds UART divisor latch and fractional divider settings for a baud rate.
// ----------------------------------------------------------------------------
// One word is handled at a time. A zero baud goes straight to its result
// with no division; any other word first gets the plain divisor. Each
// fractional pair tried costs two more passes through the single
// bit-serial divider (clock scaling, then the division by baud), each a start,
// the bit steps and a decision. The worst case tries all 105 pairs, and a
// finished word may further stall while the previous result still waits.
// The next word is taken while a result still waits on the response side.
// ----------------------------------------------------------------------------
module uart_fractional_baud_search (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ufbs_pkg::PCLK_W-1:0]    csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ufbs_pkg::BAUD_W-1:0]    req_baud,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ufbs_pkg::DIVISOR_W-1:0] rsp_divisor,
   output logic [ufbs_pkg::FRAC_W-1:0]    rsp_div_add,
   output logic [ufbs_pkg::FRAC_W-1:0]    rsp_mul_val,
   output logic                           rsp_programmed,
   output logic                           rsp_ok
);

   localparam int BW = ufbs_pkg::BAUD_W;
   localparam int PW = ufbs_pkg::PCLK_W;
   localparam int VW = ufbs_pkg::DIVISOR_W;
   localparam int FW = ufbs_pkg::FRAC_W;
   localparam int DW = ufbs_pkg::DIVIDEND_W;
   localparam int SW = ufbs_pkg::DSR_W;
   localparam int XW = PW - 4;
   localparam int LW = XW - 6;

   ufbs_pkg::state_type state_ff, state_in;

   logic [PW-1:0] pclk_ff, pclk_in;
   logic [BW-1:0] baud_ff, baud_in;
   logic [FW-1:0] add_ff, add_in;
   logic [FW-1:0] mul_ff, mul_in;
   logic [DW-1:0] scaled_ff, scaled_in;

   logic [VW-1:0] res_div_ff, res_div_in;
   logic [FW-1:0] res_add_ff, res_add_in;
   logic [FW-1:0] res_mul_ff, res_mul_in;
   logic          res_prog_ff, res_prog_in;
   logic          res_ok_ff, res_ok_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_div_ff;
   logic [FW-1:0] rsp_add_ff;
   logic [FW-1:0] rsp_mul_ff;
   logic          rsp_prog_ff;
   logic          rsp_ok_ff;
   logic          rsp_load;

   logic                     div_start;
   logic [DW-1:0]            div_dividend;
   logic [SW-1:0]            div_divisor;
   logic [DW-1:0]            div_quo;
   logic [SW-1:0]            div_rem;
   ufbs_pkg::div_status_type div_status;

   logic [XW-1:0]   x_val;
   logic [LW-1:0]   limit;
   logic [BW-1:0]   err;
   logic            rem_up;
   logic [BW:0]     plain_div;
   logic [PW+3:0]   product;
   logic [FW:0]     pair_sum;
   logic [DW:0]     pair_div;

   function automatic logic [BW-1:0] round_err(input logic [BW-1:0] rem,
                                                input logic [BW-1:0] baud);
      return (rem > (baud >> 1)) ? (baud - rem) : rem;
   endfunction

   assign x_val     = pclk_ff[PW-1:4];
   assign limit     = pclk_ff[PW-1:10];
   assign err       = round_err(div_rem, baud_ff);
   assign rem_up    = div_rem > (baud_ff >> 1);
   assign plain_div = (BW+1)'(div_quo) + (BW+1)'(rem_up);
   assign product   = (PW+4)'(pclk_ff) * (PW+4)'(mul_ff);
   assign pair_sum  = (FW+1)'(mul_ff) + (FW+1)'(add_ff);
   assign pair_div  = (DW+1)'(div_quo) + (DW+1)'(div_rem != '0);

   ufbs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .status    (div_status)
   );

   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = baud_ff;
      case (state_ff)
         ufbs_pkg::ST_PLAIN_GO: begin
            div_start    = 1'b1;
            div_dividend = DW'(x_val);
         end
         ufbs_pkg::ST_SCALE_GO: begin
            div_start    = 1'b1;
            div_dividend = product[PW+3:4];
            div_divisor  = SW'(pair_sum);
         end
         ufbs_pkg::ST_MOD_GO: begin
            div_start    = 1'b1;
            div_dividend = scaled_ff;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      pclk_in     = csr_we ? csr_wdata : pclk_ff;
      baud_in     = baud_ff;
      add_in      = add_ff;
      mul_in      = mul_ff;
      scaled_in   = scaled_ff;
      res_div_in  = res_div_ff;
      res_add_in  = res_add_ff;
      res_mul_in  = res_mul_ff;
      res_prog_in = res_prog_ff;
      res_ok_in   = res_ok_ff;
      rsp_load    = 1'b0;
      case (state_ff)
         ufbs_pkg::ST_IDLE: begin
            if (req_valid) begin
               baud_in     = req_baud;
               res_div_in  = '0;
               res_add_in  = '0;
               res_mul_in  = '0;
               res_prog_in = 1'b0;
               res_ok_in   = 1'b0;
               state_in    = (req_baud == '0) ? ufbs_pkg::ST_FINISH
                                              : ufbs_pkg::ST_PLAIN_GO;
            end
         end
         ufbs_pkg::ST_PLAIN_GO: begin
            state_in = ufbs_pkg::ST_PLAIN_WAIT;
         end
         ufbs_pkg::ST_PLAIN_WAIT: begin
            if (div_status.done) begin
               if ((BW+1)'(err) <= (BW+1)'(limit) || plain_div <= (BW+1)'(2)) begin
                  res_div_in  = plain_div[VW-1:0];
                  res_prog_in = 1'b1;
                  res_ok_in   = err <= (baud_ff >> 6);
                  state_in    = ufbs_pkg::ST_FINISH;
               end else begin
                  add_in   = ufbs_pkg::ADD_FIRST;
                  mul_in   = ufbs_pkg::ADD_FIRST + FW'(1);
                  state_in = ufbs_pkg::ST_SCALE_GO;
               end
            end
         end
         ufbs_pkg::ST_SCALE_GO: begin
            state_in = ufbs_pkg::ST_SCALE_WAIT;
         end
         ufbs_pkg::ST_SCALE_WAIT: begin
            if (div_status.done) begin
               scaled_in = div_quo;
               state_in  = ufbs_pkg::ST_MOD_GO;
            end
         end
         ufbs_pkg::ST_MOD_GO: begin
            state_in = ufbs_pkg::ST_MOD_WAIT;
         end
         ufbs_pkg::ST_MOD_WAIT: begin
            if (div_status.done) begin
               if ((BW+1)'(err) <= (BW+1)'(limit)) begin
                  res_div_in  = pair_div[VW-1:0];
                  res_add_in  = add_ff;
                  res_mul_in  = mul_ff;
                  res_prog_in = 1'b1;
                  res_ok_in   = 1'b1;
                  state_in    = ufbs_pkg::ST_FINISH;
               end else if (mul_ff != ufbs_pkg::MUL_LAST) begin
                  mul_in   = mul_ff + FW'(1);
                  state_in = ufbs_pkg::ST_SCALE_GO;
               end else if (add_ff != ufbs_pkg::ADD_LAST) begin
                  add_in   = add_ff + FW'(1);
                  mul_in   = add_ff + FW'(2);
                  state_in = ufbs_pkg::ST_SCALE_GO;
               end else begin
                  state_in = ufbs_pkg::ST_FINISH;
               end
            end
         end
         ufbs_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ufbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ufbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ufbs_pkg::ST_IDLE;
         pclk_ff      <= ufbs_pkg::PCLK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pclk_ff      <= pclk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      baud_ff     <= baud_in;
      add_ff      <= add_in;
      mul_ff      <= mul_in;
      scaled_ff   <= scaled_in;
      res_div_ff  <= res_div_in;
      res_add_ff  <= res_add_in;
      res_mul_ff  <= res_mul_in;
      res_prog_ff <= res_prog_in;
      res_ok_ff   <= res_ok_in;
      if (rsp_load) begin
         rsp_div_ff  <= res_div_ff;
         rsp_add_ff  <= res_add_ff;
         rsp_mul_ff  <= res_mul_ff;
         rsp_prog_ff <= res_prog_ff;
         rsp_ok_ff   <= res_ok_ff;
      end
   end

   assign req_ready      = state_ff == ufbs_pkg::ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_divisor    = rsp_div_ff;
   assign rsp_div_add    = rsp_add_ff;
   assign rsp_mul_val    = rsp_mul_ff;
   assign rsp_programmed = rsp_prog_ff;
   assign rsp_ok         = rsp_ok_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ufbs_pkg::ST_PLAIN_WAIT ||
                           state_ff == ufbs_pkg::ST_SCALE_WAIT ||
                           state_ff == ufbs_pkg::ST_MOD_WAIT))
      else $error("divider finished outside a wait state");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ufbs_pkg::ST_SCALE_GO || state_ff == ufbs_pkg::ST_SCALE_WAIT ||
       state_ff == ufbs_pkg::ST_MOD_GO || state_ff == ufbs_pkg::ST_MOD_WAIT)
      |-> (add_ff >= ufbs_pkg::ADD_FIRST && mul_ff > add_ff &&
           mul_ff <= ufbs_pkg::MUL_LAST))
      else $error("fractional pair out of order");

   a_ok_needs_prog: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ok_ff || rsp_prog_ff))
      else $error("ok without programming");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_prog_ff) |->
      (rsp_div_ff == '0 && rsp_add_ff == '0 && rsp_mul_ff == '0))
      else $error("unprogrammed word carries settings");

   a_load_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ufbs_pkg::ST_FINISH))
      else $error("response raised outside finish");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fractional UART baud divider search. Baud
// words are pushed through the request channel in random bursts. Each
// accepted word is run through a local divisor search to get the expected
// settings. The response channel stalls on shifting patterns, and once on
// a long hold-off. Responses are compared in order. The peripheral clock
// register is changed between phases, including its extreme values.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BW           = ufbs_pkg::BAUD_W;
   localparam int PW           = ufbs_pkg::PCLK_W;
   localparam int VW           = ufbs_pkg::DIVISOR_W;
   localparam int FW           = ufbs_pkg::FRAC_W;
   localparam int PERIOD       = 20;
   localparam int WATCHDOG_MAX = 30000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SEARCH_TAIL  = 6000;

   typedef struct packed {
      logic [VW-1:0] divisor;
      logic [FW-1:0] div_add;
      logic [FW-1:0] mul_val;
      logic          programmed;
      logic          ok;
   } baud_setting_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_we = 1'b0;
   logic [PW-1:0] csr_wdata = ufbs_pkg::PCLK_RESET;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [BW-1:0] req_baud = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [VW-1:0] rsp_divisor;
   logic [FW-1:0] rsp_div_add;
   logic [FW-1:0] rsp_mul_val;
   logic          rsp_programmed;
   logic          rsp_ok;

   logic [PW-1:0]     pclk_model = ufbs_pkg::PCLK_RESET;
   baud_setting_type  due_settings[$];
   baud_setting_type  want_setting, got_setting;
   int                bad_results = 0;
   int                reports = 0;
   int                idle_cycles = 0;
   int                burst_left = 0;
   bit                gapless = 1'b0;
   bit                hold_request = 1'b0;
   int                hold_left = 0;
   int                pattern_left = 0;
   logic [7:0]        stall_pattern = 8'hFF;

   always #(PERIOD / 2) clock = ~clock;

   uart_fractional_baud_search uut (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_baud      (req_baud),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_divisor   (rsp_divisor),
      .rsp_div_add   (rsp_div_add),
      .rsp_mul_val   (rsp_mul_val),
      .rsp_programmed(rsp_programmed),
      .rsp_ok        (rsp_ok)
   );

   function automatic baud_setting_type divider_for_baud(
         input logic [BW-1:0] baud);
      baud_setting_type s;
      longint unsigned  rate, clk, x, tol, q, r, e, scaled, sr, se;
      int               add, mul;
      s = '0;
      if (baud == '0)
         return s;
      rate = 64'(baud);
      clk  = 64'(pclk_model);
      x    = clk / 16;
      tol  = x >> 6;
      q    = x / rate;
      r    = x % rate;
      e    = (r > (rate >> 1)) ? rate - r : r;
      if (r > (rate >> 1))
         q++;
      if (e <= tol || q <= 2) begin
         s.divisor    = q[VW-1:0];
         s.programmed = 1'b1;
         s.ok         = (e <= (rate >> 6));
         return s;
      end
      for (add = int'(ufbs_pkg::ADD_FIRST); add <= int'(ufbs_pkg::ADD_LAST); add++) begin
         for (mul = add + 1; mul <= int'(ufbs_pkg::MUL_LAST); mul++) begin
            scaled = clk * longint'(mul) / 16 / longint'(mul + add);
            sr     = scaled % rate;
            se     = (sr > (rate >> 1)) ? rate - sr : sr;
            if (se <= tol) begin
               q            = (scaled + rate - 1) / rate;
               s.divisor    = q[VW-1:0];
               s.div_add    = add[FW-1:0];
               s.mul_val    = mul[FW-1:0];
               s.programmed = 1'b1;
               s.ok         = 1'b1;
               return s;
            end
         end
      end
      return s;
   endfunction

   task automatic send_baud(input logic [BW-1:0] baud);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         if (!gapless && $urandom_range(0, 3) != 0)
            gap = $urandom_range(1, 12);
         burst_left = gapless ? 1 : $urandom_range(1, 10);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_baud  = baud;
      do @(posedge clock); while (!req_ready);
      due_settings.push_back(divider_for_baud(baud));
      burst_left--;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (due_settings.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_clock(input logic [PW-1:0] hz);
      drain_results();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = hz;
      @(posedge clock);
      pclk_model = hz;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic test_reset_clock();
      send_baud(23'd0);
      send_baud(23'd1);
      send_baud(23'd9600);
      send_baud(23'h7FFFFF);
      send_baud(23'd1562500);
      send_baud(23'd781250);
      send_baud(23'd900000);
      send_baud(23'h555555);
      send_baud(23'h2AAAAA);
   endtask

   task automatic test_fraction();
      set_clock(27'd25000000);
      send_baud(23'd115200);
      send_baud(23'd57600);
      send_baud(23'd38400);
      send_baud(23'd230400);
      send_baud(23'd250000);
      send_baud(23'd312500);
      send_baud(23'd460800);
      send_baud(23'd500000);
      send_baud(23'd200000);
   endtask

   task automatic test_backpressure();
      gapless      = 1'b1;
      hold_request = 1'b1;
      repeat (12) send_baud(BW'($urandom_range(1200, 19200)));
      gapless = 1'b0;
   endtask

   task automatic test_clock_extremes();
      set_clock(27'd1000000);
      send_baud(23'd1);
      send_baud(23'd2400);
      send_baud(23'd62500);
      set_clock(27'd120000000);
      send_baud(23'd1);
      send_baud(23'd7500000);
      send_baud(23'd921600);
      set_clock('0);
      send_baud(23'd9600);
      set_clock(27'h7FFFFFF);
      send_baud(23'h7FFFFF);
      send_baud(23'd3000000);
   endtask

   task automatic test_random_sweep(input int count);
      logic [PW-1:0] hz;
      logic [BW-1:0] baud;
      int unsigned   x, d, k;
      k = $urandom_range(0, 5);
      if (k == 0)
         hz = 27'd1000000;
      else if (k == 1)
         hz = 27'd120000000;
      else
         hz = PW'($urandom_range(1000000, 120000000));
      set_clock(hz);
      x = 32'(hz) / 16;
      repeat (count) begin
         k = $urandom_range(0, 9);
         if (k < 6) begin
            d    = $urandom_range(3, 40);
            baud = BW'($urandom_range(x / (d + 1) + 1, x / d));
         end else if (k < 9) begin
            baud = BW'($urandom_range(0, 23'h7FFFFF));
         end else begin
            baud = BW'($urandom_range(1, 2000));
         end
         send_baud(baud);
      end
   endtask

   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready = 1'b0;
      end else begin
         if (pattern_left == 0) begin
            stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            pattern_left  = $urandom_range(8, 64);
         end
         pattern_left--;
         rsp_ready     = stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_setting = {rsp_divisor, rsp_div_add, rsp_mul_val, rsp_programmed, rsp_ok};
         if (due_settings.size() == 0) begin
            bad_results++;
            if (reports < 10) begin
               reports++;
               $display("unexpected result: div %0d add %0d mul %0d prog %0b ok %0b",
                  got_setting.divisor, got_setting.div_add, got_setting.mul_val,
                  got_setting.programmed, got_setting.ok);
            end
         end else begin
            want_setting = due_settings.pop_front();
            if (got_setting.divisor !== want_setting.divisor ||
                  got_setting.div_add !== want_setting.div_add ||
                  got_setting.mul_val !== want_setting.mul_val ||
                  got_setting.programmed !== want_setting.programmed ||
                  got_setting.ok !== want_setting.ok) begin
               bad_results++;
               if (reports < 10) begin
                  reports++;
                  $display("mismatch at pclk %0d: expected div %0d add %0d mul %0d",
                     pclk_model, want_setting.divisor, want_setting.div_add,
                     want_setting.mul_val);
                  $display("   expected prog %0b ok %0b", want_setting.programmed,
                     want_setting.ok);
                  $display("   got div %0d add %0d mul %0d prog %0b ok %0b",
                     got_setting.divisor, got_setting.div_add, got_setting.mul_val,
                     got_setting.programmed, got_setting.ok);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_clock();
      test_fraction();
      test_backpressure();
      test_clock_extremes();
      repeat (4) test_random_sweep(16);
      drain_results();
      repeat (SEARCH_TAIL) @(posedge clock);
      if (bad_results == 0 && due_settings.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ===== uart_fractional_baud_search.f =====
hdl/ufbs_pkg.sv
hdl/ufbs_div.sv
hdl/uart_fractional_baud_search.sv
sim/tb_top.sv
